[sv/lrf_pkg.sv]
// ============================================================================
// lrf_pkg
// Shared types, constants and helpers for the lidar repulsion field block.
// ============================================================================
package lrf_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG,
        ST_CDIV,
        ST_HDIV,
        ST_FMUL,
        ST_FDIV,
        ST_TRIG,
        ST_XMUL,
        ST_YMUL,
        ST_STEP,
        ST_SQX,
        ST_SQY,
        ST_SQSUM,
        ST_ROOT,
        ST_NXMUL,
        ST_NXSTART,
        ST_NXWAIT,
        ST_NYSTART,
        ST_NYWAIT,
        ST_TAN,
        ST_TTRIG,
        ST_TXMUL,
        ST_TYMUL,
        ST_OUT
    } state_t;

    localparam logic [2:0] CFG_START_ANGLE = 3'd0;
    localparam logic [2:0] CFG_END_ANGLE   = 3'd1;
    localparam logic [2:0] CFG_ANGLE_STEP  = 3'd2;
    localparam logic [2:0] CFG_CONE_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_REP_WEIGHT  = 3'd4;

    localparam int BACK_LIMIT    = 14297;
    localparam int HALF_PI_Q13   = 12868;
    localparam int PI_Q13        = 25736;
    localparam int CORDIC_GAIN   = 39797;
    localparam int TANGENT_Q12   = 30720;
    localparam int REP_RANGE     = 700;
    localparam int NEAR_LIMIT    = 350;
    localparam int MIN_RANGE     = 50;
    localparam int FRONT_INIT    = 10000;
    localparam int NEAREST_INIT  = 100000;
    localparam int F_DIVISOR     = 490000;
    // repulsion magnitude: floor((256*n^2 + F_BIAS) / 30625) via reciprocal
    // multiply by F_RECIP = ceil(2^F_SHIFT / 30625), exact for n up to 650
    localparam int F_BIAS        = 15312;
    localparam int F_RECIP       = 143609682;
    localparam int F_SHIFT       = 42;
    localparam int SQ_THRESH     = 16;
    localparam int UNIT_Q12      = 4096;
    localparam int Q14_ONE       = 16384;

    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_W      = 20;
    localparam int DIV_NUM_W     = 48;
    localparam int DIV_DEN_W     = 32;

    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:  v = 16'd51472;
            4'd1:  v = 16'd30386;
            4'd2:  v = 16'd16055;
            4'd3:  v = 16'd8150;
            4'd4:  v = 16'd4091;
            4'd5:  v = 16'd2047;
            4'd6:  v = 16'd1024;
            4'd7:  v = 16'd512;
            4'd8:  v = 16'd256;
            4'd9:  v = 16'd128;
            4'd10: v = 16'd64;
            4'd11: v = 16'd32;
            4'd12: v = 16'd16;
            4'd13: v = 16'd8;
            4'd14: v = 16'd4;
            4'd15: v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // round to nearest, halves away from zero, divide by 2^14
    function automatic logic signed [17:0] round_q14(input logic signed [31:0] p);
        logic [31:0] mag;
        logic [31:0] q;
        logic signed [17:0] r;
        mag = p[31] ? 32'(-p) : 32'(p);
        q   = (mag + 32'd8192) >> 14;
        r   = $signed(q[17:0]);
        return p[31] ? -r : r;
    endfunction

endpackage

[sv/lrf_cordic.sv]
// ============================================================================
// lrf_cordic
// Iterative sine/cosine unit, one rotation per cycle, Q3.13 in, Q2.14 out.
// ============================================================================
module lrf_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] angle,
    output logic               busy,
    output logic               done,
    output logic signed [15:0] sin_q14,
    output logic signed [15:0] cos_q14
);

    localparam int W = lrf_pkg::CORDIC_W;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               neg_reg;
    logic signed [W-1:0] x_reg, y_reg, z_reg;
    logic signed [W-1:0] x_next, y_next, z_next;
    logic [3:0]         step_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic signed [16:0] a_ext, a_fold;
    logic               a_neg;
    logic signed [W-1:0] dx, dy, at;
    logic signed [W-1:0] xr, yr;
    logic signed [15:0] xc, yc;

    always_comb begin
        a_ext  = {angle[15], angle};
        a_neg  = 1'b0;
        a_fold = a_ext;
        if (a_ext > 17'(lrf_pkg::HALF_PI_Q13)) begin
            a_fold = a_ext - 17'(lrf_pkg::PI_Q13);
            a_neg  = 1'b1;
        end else if (a_ext < -17'(lrf_pkg::HALF_PI_Q13)) begin
            a_fold = a_ext + 17'(lrf_pkg::PI_Q13);
            a_neg  = 1'b1;
        end
    end

    always_comb begin
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = $signed({4'b0, lrf_pkg::atan_q16(step_reg)});
        if (!z_reg[W-1]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + at;
        end
        xr = (x_next + W'(2)) >>> 2;
        yr = (y_next + W'(2)) >>> 2;
        if (xr > W'(lrf_pkg::Q14_ONE))       xc = 16'(lrf_pkg::Q14_ONE);
        else if (xr < -W'(lrf_pkg::Q14_ONE)) xc = -16'(lrf_pkg::Q14_ONE);
        else                                 xc = xr[15:0];
        if (yr > W'(lrf_pkg::Q14_ONE))       yc = 16'(lrf_pkg::Q14_ONE);
        else if (yr < -W'(lrf_pkg::Q14_ONE)) yc = -16'(lrf_pkg::Q14_ONE);
        else                                 yc = yr[15:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
        end else if (busy_reg && step_reg == 4'(lrf_pkg::CORDIC_STEPS - 1)) begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg    <= W'(lrf_pkg::CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= {a_fold, 3'b000};
            neg_reg  <= a_neg;
            step_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            step_reg <= step_reg + 4'd1;
            if (step_reg == 4'(lrf_pkg::CORDIC_STEPS - 1)) begin
                cos_reg <= neg_reg ? -xc : xc;
                sin_reg <= neg_reg ? -yc : yc;
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign sin_q14 = sin_reg;
    assign cos_q14 = cos_reg;

endmodule

[sv/lrf_div.sv]
// ============================================================================
// lrf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module lrf_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, done_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic             last_bit;

    assign trial    = {rem_reg, q_reg[NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign last_bit = cnt_reg == CNT_W'(NUM_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && last_bit;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last_bit) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;

endmodule

[sv/lidar_repulsion_field.sv]
// ============================================================================
// lidar_repulsion_field
// Obstacle repulsion force from one lidar scan, one ray per input word.
// ============================================================================
// Usage:
//   s_ channel: one ray per word, in scan order. s_tdata = range_mm,
//   s_tuser = no-echo flag, s_tlast marks the final ray of the scan.
//   m_ channel: one word per scan, issued after the ray carrying s_tlast:
//   force_x, force_y (Q12) and the frontal minimum range in mm.
//   cfg_ channel: register writes, always ready; write only while idle.
// Sequencing: each ray runs the two sector bound divides on the shared divider,
//   and a ray that adds repulsion also runs the sine/cosine unit; no new ray is
//   accepted until the last one is done. The final ray may also run the 32-step
//   square root, two normalizing divides and the tangent.
// Reset: registers take their default values and the scan state is cleared.
// Stall: the result sits in an output register; the next ray is accepted
//   while it waits, and a further result waits until it is taken.
// ============================================================================
module lidar_repulsion_field #(
    parameter int MAX_RAYS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // ray input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] range_mm
    input  logic        s_tuser,    // [0] range_infinite
    input  logic        s_tlast,
    // force output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // [16:0] force_x, [33:17] force_y, [47:34] front_min_mm
);

    localparam int IDX_W = $clog2(MAX_RAYS);

    lrf_pkg::state_t state_reg, state_next;

    logic signed [15:0] start_angle_reg, end_angle_reg;
    logic [12:0]        angle_step_reg;
    logic [15:0]        cone_width_reg;
    logic [13:0]        rep_weight_reg;

    logic [15:0]        range_reg;
    logic               inf_reg, last_reg;

    logic [IDX_W-1:0]   ray_index_reg;
    logic               overflow_reg;
    logic signed [31:0] sum_x_reg, sum_y_reg;
    logic               active_reg;
    logic [16:0]        nearest_mm_reg;
    logic signed [15:0] nearest_ang_reg;
    logic [13:0]        front_min_reg;

    logic signed [15:0] angle_reg;
    logic signed [17:0] center_reg;
    logic [11:0]        f_reg;
    logic signed [63:0] prod_reg;
    logic [63:0]        sq_reg;
    logic [63:0]        root_v_reg, root_r_reg;
    logic [4:0]         root_cnt_reg;
    logic signed [33:0] fx_reg, fy_reg;
    logic               div_neg_reg;

    logic               m_valid_reg;
    logic [47:0]        m_data_reg;

    logic signed [32:0] mul_a, mul_b;
    logic               div_start, div_busy, div_done;
    logic [47:0]        div_num, div_quot;
    logic [31:0]        div_den;
    logic               cor_start, cor_busy, cor_done;
    logic signed [15:0] cor_angle, cor_sin, cor_cos;

    logic               s_accept, out_load;
    logic [12:0]        step_eff;
    logic [13:0]        step2;
    logic signed [16:0] span;
    logic [16:0]        span_mag;
    logic signed [26:0] ang_full;
    logic signed [15:0] ang_sat;
    logic signed [17:0] half_s, sec_lo, sec_hi, idx_s;
    logic               in_sector, front_hit, echo_ok, back_ok, repulse;
    logic [9:0]         rep_num;
    logic [63:0]        prod_mag;
    logic [31:0]        den_val;
    logic [63:0]        root_bit, root_try;
    logic [5:0]         root_pos;
    logic signed [15:0] tan_x, tan_y;
    logic signed [17:0] rnd_term;
    logic [16:0]        out_fx, out_fy;

    // ---------------------------------------------------------------- helpers
    function automatic logic [16:0] sat17(input logic signed [33:0] v);
        if (v > 34'sd65535)  return 17'h0FFFF;
        if (v < -34'sd65536) return 17'h10000;
        return v[16:0];
    endfunction

    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == lrf_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    assign step_eff = (angle_step_reg == 13'd0) ? 13'd1 : angle_step_reg;
    assign step2    = {step_eff, 1'b0};
    assign span     = {end_angle_reg[15], end_angle_reg} - {start_angle_reg[15], start_angle_reg};
    assign span_mag = span[16] ? 17'(-span) : 17'(span);

    assign ang_full = {{11{start_angle_reg[15]}}, start_angle_reg} + $signed({2'b0, prod_reg[24:0]});
    always_comb begin
        if (ang_full > 27'sd32767)       ang_sat = 16'sh7FFF;
        else if (ang_full < -27'sd32768) ang_sat = 16'sh8000;
        else                             ang_sat = ang_full[15:0];
    end

    assign half_s    = $signed({2'b0, div_quot[15:0]});
    assign sec_lo    = center_reg - half_s;
    assign sec_hi    = center_reg + half_s;
    assign idx_s     = $signed(18'(ray_index_reg));
    assign in_sector = (idx_s >= sec_lo) && (idx_s < sec_hi);
    assign front_hit = !inf_reg && range_reg > 16'(lrf_pkg::MIN_RANGE) && in_sector
                       && range_reg < {2'b0, front_min_reg};
    assign echo_ok   = !inf_reg && range_reg >= 16'(lrf_pkg::MIN_RANGE);
    assign back_ok   = angle_reg <= 16'(lrf_pkg::BACK_LIMIT)
                       && angle_reg >= -16'(lrf_pkg::BACK_LIMIT);
    assign repulse   = echo_ok && back_ok && range_reg < 16'(lrf_pkg::REP_RANGE);
    assign rep_num   = 10'(16'(lrf_pkg::REP_RANGE) - range_reg);

    assign prod_mag  = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
    assign den_val   = (root_r_reg >= 64'(lrf_pkg::UNIT_Q12)) ? root_r_reg[31:0]
                                                               : 32'(lrf_pkg::UNIT_Q12);
    assign root_pos  = 6'd62 - {root_cnt_reg, 1'b0};
    assign root_bit  = 64'd1 << root_pos;
    assign root_try  = root_r_reg + root_bit;

    assign tan_x     = nearest_ang_reg[15] ? -cor_sin : cor_sin;
    assign tan_y     = nearest_ang_reg[15] ? cor_cos : -cor_cos;
    assign rnd_term  = lrf_pkg::round_q14(prod_reg[31:0]);

    assign out_fx    = sat17(fx_reg);
    assign out_fy    = sat17(fy_reg);

    // ---------------------------------------------------------------- units
    lrf_div #(
        .NUM_W (lrf_pkg::DIV_NUM_W),
        .DEN_W (lrf_pkg::DIV_DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    lrf_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .busy    (cor_busy),
        .done    (cor_done),
        .sin_q14 (cor_sin),
        .cos_q14 (cor_cos)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrf_pkg::ST_IDLE:    if (s_accept) begin
                                     state_next = overflow_reg ? lrf_pkg::ST_STEP
                                                               : lrf_pkg::ST_ANG;
                                 end
            lrf_pkg::ST_ANG:     state_next = lrf_pkg::ST_CDIV;
            lrf_pkg::ST_CDIV:    if (div_done) state_next = lrf_pkg::ST_HDIV;
            lrf_pkg::ST_HDIV:    if (div_done) begin
                                     state_next = repulse ? lrf_pkg::ST_FMUL : lrf_pkg::ST_STEP;
                                 end
            lrf_pkg::ST_FMUL:    state_next = lrf_pkg::ST_FDIV;
            lrf_pkg::ST_FDIV:    state_next = lrf_pkg::ST_TRIG;
            lrf_pkg::ST_TRIG:    if (cor_done) state_next = lrf_pkg::ST_XMUL;
            lrf_pkg::ST_XMUL:    state_next = lrf_pkg::ST_YMUL;
            lrf_pkg::ST_YMUL:    state_next = lrf_pkg::ST_STEP;
            lrf_pkg::ST_STEP:    state_next = last_reg ? lrf_pkg::ST_SQX : lrf_pkg::ST_IDLE;
            lrf_pkg::ST_SQX:     state_next = lrf_pkg::ST_SQY;
            lrf_pkg::ST_SQY:     state_next = lrf_pkg::ST_SQSUM;
            lrf_pkg::ST_SQSUM:   state_next = (active_reg && sq_reg > 64'(lrf_pkg::SQ_THRESH))
                                              ? lrf_pkg::ST_ROOT : lrf_pkg::ST_TAN;
            lrf_pkg::ST_ROOT:    if (root_cnt_reg == 5'd31) state_next = lrf_pkg::ST_NXMUL;
            lrf_pkg::ST_NXMUL:   state_next = lrf_pkg::ST_NXSTART;
            lrf_pkg::ST_NXSTART: state_next = lrf_pkg::ST_NXWAIT;
            lrf_pkg::ST_NXWAIT:  if (div_done) state_next = lrf_pkg::ST_NYSTART;
            lrf_pkg::ST_NYSTART: state_next = lrf_pkg::ST_NYWAIT;
            lrf_pkg::ST_NYWAIT:  if (div_done) state_next = lrf_pkg::ST_TAN;
            lrf_pkg::ST_TAN:     state_next = (nearest_mm_reg < 17'(lrf_pkg::NEAR_LIMIT))
                                              ? lrf_pkg::ST_TTRIG : lrf_pkg::ST_OUT;
            lrf_pkg::ST_TTRIG:   if (cor_done) state_next = lrf_pkg::ST_TXMUL;
            lrf_pkg::ST_TXMUL:   state_next = lrf_pkg::ST_TYMUL;
            lrf_pkg::ST_TYMUL:   state_next = lrf_pkg::ST_OUT;
            lrf_pkg::ST_OUT:     if (out_load) state_next = lrf_pkg::ST_IDLE;
            default:             state_next = lrf_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- unit controls
    always_comb begin
        mul_a     = $signed({1'b0, 32'(ray_index_reg)});
        mul_b     = $signed({20'b0, angle_step_reg});
        div_start = 1'b0;
        div_num   = 48'(span_mag);
        div_den   = 32'(step2);
        cor_start = 1'b0;
        cor_angle = angle_reg;
        case (state_reg)
            lrf_pkg::ST_ANG: begin
                div_start = 1'b1;
            end
            lrf_pkg::ST_CDIV: begin
                div_start = div_done;
                div_num   = 48'(cone_width_reg);
            end
            lrf_pkg::ST_HDIV: begin
                mul_a = $signed({23'b0, rep_num});
                mul_b = $signed({23'b0, rep_num});
            end
            lrf_pkg::ST_FMUL: begin
                mul_a = $signed({5'b0, prod_reg[19:0], 8'b0}) + 33'(lrf_pkg::F_BIAS);
                mul_b = 33'(lrf_pkg::F_RECIP);
            end
            lrf_pkg::ST_FDIV: begin
                cor_start = 1'b1;
            end
            lrf_pkg::ST_TRIG: begin
                mul_a = -33'(cor_cos);
                mul_b = $signed({21'b0, f_reg});
            end
            lrf_pkg::ST_XMUL: begin
                mul_a = -33'(cor_sin);
                mul_b = $signed({21'b0, f_reg});
            end
            lrf_pkg::ST_STEP: begin
                mul_a = 33'(sum_x_reg);
                mul_b = 33'(sum_x_reg);
            end
            lrf_pkg::ST_SQX: begin
                mul_a = 33'(sum_y_reg);
                mul_b = 33'(sum_y_reg);
            end
            lrf_pkg::ST_NXMUL: begin
                mul_a = fx_reg[32:0];
                mul_b = $signed({19'b0, rep_weight_reg});
            end
            lrf_pkg::ST_NXSTART, lrf_pkg::ST_NYSTART: begin
                div_start = 1'b1;
                div_num   = prod_mag[47:0] + 48'(den_val[31:1]);
                div_den   = den_val;
            end
            lrf_pkg::ST_NXWAIT: begin
                mul_a = fy_reg[32:0];
                mul_b = $signed({19'b0, rep_weight_reg});
            end
            lrf_pkg::ST_TAN: begin
                cor_start = nearest_mm_reg < 17'(lrf_pkg::NEAR_LIMIT);
                cor_angle = nearest_ang_reg;
            end
            lrf_pkg::ST_TTRIG: begin
                mul_a = 33'(tan_x);
                mul_b = 33'(lrf_pkg::TANGENT_Q12);
            end
            lrf_pkg::ST_TXMUL: begin
                mul_a = 33'(tan_y);
                mul_b = 33'(lrf_pkg::TANGENT_Q12);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- control regs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lrf_pkg::ST_IDLE;
            start_angle_reg <= -16'sd25736;
            end_angle_reg   <= 16'sd25736;
            angle_step_reg  <= 13'd143;
            cone_width_reg  <= 16'd11437;
            rep_weight_reg  <= 14'd3686;
            m_valid_reg     <= 1'b0;
            ray_index_reg   <= '0;
            overflow_reg    <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            active_reg      <= 1'b0;
            nearest_mm_reg  <= 17'(lrf_pkg::NEAREST_INIT);
            nearest_ang_reg <= '0;
            front_min_reg   <= 14'(lrf_pkg::FRONT_INIT);
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lrf_pkg::CFG_START_ANGLE: start_angle_reg <= $signed(cfg_data);
                    lrf_pkg::CFG_END_ANGLE:   end_angle_reg   <= $signed(cfg_data);
                    lrf_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_data[12:0];
                    lrf_pkg::CFG_CONE_WIDTH:  cone_width_reg  <= cfg_data;
                    lrf_pkg::CFG_REP_WEIGHT:  rep_weight_reg  <= cfg_data[13:0];
                    default:                  ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                lrf_pkg::ST_HDIV: begin
                    if (div_done) begin
                        if (front_hit) front_min_reg <= range_reg[13:0];
                        if (echo_ok && {1'b0, range_reg} < nearest_mm_reg) begin
                            nearest_mm_reg  <= {1'b0, range_reg};
                            nearest_ang_reg <= angle_reg;
                        end
                    end
                end
                lrf_pkg::ST_XMUL: sum_x_reg <= sum_x_reg + 32'(rnd_term);
                lrf_pkg::ST_YMUL: begin
                    sum_y_reg  <= sum_y_reg + 32'(rnd_term);
                    active_reg <= 1'b1;
                end
                lrf_pkg::ST_STEP: begin
                    if (!overflow_reg) begin
                        if ((IDX_W + 1)'(ray_index_reg) + (IDX_W + 1)'(1)
                                >= (IDX_W + 1)'(MAX_RAYS)) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            ray_index_reg <= ray_index_reg + IDX_W'(1);
                        end
                    end
                end
                lrf_pkg::ST_OUT: begin
                    if (out_load) begin
                        ray_index_reg   <= '0;
                        overflow_reg    <= 1'b0;
                        sum_x_reg       <= '0;
                        sum_y_reg       <= '0;
                        active_reg      <= 1'b0;
                        nearest_mm_reg  <= 17'(lrf_pkg::NEAREST_INIT);
                        nearest_ang_reg <= '0;
                        front_min_reg   <= 14'(lrf_pkg::FRONT_INIT);
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath regs
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a * mul_b);
        if (s_accept) begin
            range_reg <= s_tdata;
            inf_reg   <= s_tuser;
            last_reg  <= s_tlast;
        end
        case (state_reg)
            lrf_pkg::ST_ANG:  angle_reg <= ang_sat;
            lrf_pkg::ST_CDIV: begin
                if (div_done) begin
                    center_reg <= span[16] ? -$signed({1'b0, div_quot[16:0]})
                                           : $signed({1'b0, div_quot[16:0]});
                end
            end
            lrf_pkg::ST_FDIV: f_reg <= prod_reg[lrf_pkg::F_SHIFT +: 12];
            lrf_pkg::ST_STEP: begin
                fx_reg <= 34'(sum_x_reg);
                fy_reg <= 34'(sum_y_reg);
            end
            lrf_pkg::ST_SQX:   sq_reg <= prod_reg;
            lrf_pkg::ST_SQY:   sq_reg <= sq_reg + prod_reg;
            lrf_pkg::ST_SQSUM: begin
                root_v_reg   <= sq_reg;
                root_r_reg   <= '0;
                root_cnt_reg <= '0;
            end
            lrf_pkg::ST_ROOT: begin
                root_cnt_reg <= root_cnt_reg + 5'd1;
                if (root_v_reg >= root_try) begin
                    root_v_reg <= root_v_reg - root_try;
                    root_r_reg <= (root_r_reg >> 1) + root_bit;
                end else begin
                    root_r_reg <= root_r_reg >> 1;
                end
            end
            lrf_pkg::ST_NXSTART, lrf_pkg::ST_NYSTART: div_neg_reg <= prod_reg[63];
            lrf_pkg::ST_NXWAIT: begin
                if (div_done) begin
                    fx_reg <= div_neg_reg ? -$signed(div_quot[33:0]) : $signed(div_quot[33:0]);
                end
            end
            lrf_pkg::ST_NYWAIT: begin
                if (div_done) begin
                    fy_reg <= div_neg_reg ? -$signed(div_quot[33:0]) : $signed(div_quot[33:0]);
                end
            end
            lrf_pkg::ST_TXMUL: fx_reg <= fx_reg + 34'(rnd_term);
            lrf_pkg::ST_TYMUL: fy_reg <= fy_reg + 34'(rnd_term);
            lrf_pkg::ST_OUT:   if (out_load) m_data_reg <= {front_min_reg, out_fy, out_fx};
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == lrf_pkg::ST_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // ---------------------------------------------------------------- checks
    a_front_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        front_min_reg <= 14'(lrf_pkg::FRONT_INIT))
        else $error("front minimum above its initial value");

    a_overflow_index: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> ray_index_reg == IDX_W'(MAX_RAYS - 1))
        else $error("ray overflow without full index");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_start |-> !cor_busy)
        else $error("sine/cosine unit started while busy");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && state_reg == lrf_pkg::ST_IDLE)
        else $error("result word not presented after load");

endmodule

[verif/lrf_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// lrf_checker
// Watches the config, ray and force channels of lidar_repulsion_field. Keeps
// its own copy of the registers and scan state, predicts the force word for
// each scan and compares it field by field with the word the block issues.
// ============================================================================
module lrf_checker #(
    parameter int MAX_RAYS = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic signed [16:0] fx;
        logic signed [16:0] fy;
        logic [13:0]        fmin;
    } force_word_t;

    localparam int ATAN_TBL [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                    256, 128, 64, 32, 16, 8, 4, 2};

    force_word_t force_q[$];

    int          start_ang, end_ang, step, cone, weight;
    int unsigned ray_idx, active, near_mm, front_mm;
    int          sum_x, sum_y, near_ang;
    bit          overrun;

    initial begin
        errors = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint round_div(input longint n, input longint d);
        longint a;
        longint q;
        a = (n < 0) ? -n : n;
        q = (a + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic int clip_q14(input int v);
        if (v > lrf_pkg::Q14_ONE) return lrf_pkg::Q14_ONE;
        if (v < -lrf_pkg::Q14_ONE) return -lrf_pkg::Q14_ONE;
        return v;
    endfunction

    task automatic sin_cos(input int ang, output int s, output int c);
        bit flip;
        int x, y, z, dx, dy;
        flip = 0;
        x = lrf_pkg::CORDIC_GAIN;
        y = 0;
        if (ang > lrf_pkg::HALF_PI_Q13) begin
            ang -= lrf_pkg::PI_Q13;
            flip = 1;
        end else if (ang < -lrf_pkg::HALF_PI_Q13) begin
            ang += lrf_pkg::PI_Q13;
            flip = 1;
        end
        z = ang * 8;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        x = clip_q14((x + 2) >>> 2);
        y = clip_q14((y + 2) >>> 2);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [16:0] clip17(input longint v);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[16:0];
    endfunction

    task automatic clear_scan();
        ray_idx = 0; sum_x = 0; sum_y = 0; active = 0;
        near_mm = lrf_pkg::NEAREST_INIT; near_ang = 0; front_mm = lrf_pkg::FRONT_INIT;
        overrun = 0;
    endtask

    task automatic take_ray(input int unsigned d, input bit no_echo);
        int     a, st, center, half, s, c, num;
        longint f;
        a = start_ang + int'(ray_idx) * step;
        st = (step == 0) ? 1 : step;
        center = (end_ang - start_ang) / (2 * st);
        half = cone / (2 * st);
        if (a > 32767) a = 32767;
        if (a < -32768) a = -32768;
        if (!no_echo && d > lrf_pkg::MIN_RANGE && int'(ray_idx) >= center - half
                && int'(ray_idx) < center + half && d < front_mm)
            front_mm = d;
        if (!no_echo && d >= lrf_pkg::MIN_RANGE) begin
            if (d < near_mm) begin
                near_mm = d;
                near_ang = a;
            end
            if (a <= lrf_pkg::BACK_LIMIT && a >= -lrf_pkg::BACK_LIMIT
                    && d < lrf_pkg::REP_RANGE) begin
                num = lrf_pkg::REP_RANGE - int'(d);
                f = round_div(longint'(num) * num * 4096, lrf_pkg::F_DIVISOR);
                sin_cos(a, s, c);
                sum_x += int'(round_div(-longint'(c) * f, lrf_pkg::Q14_ONE));
                sum_y += int'(round_div(-longint'(s) * f, lrf_pkg::Q14_ONE));
                if (active < 2047) active++;
            end
        end
        if (ray_idx + 1 >= MAX_RAYS) overrun = 1;
        else ray_idx++;
    endtask

    task automatic finish_scan();
        longint          fx, fy, den;
        longint unsigned sq;
        int              s, c, tx, ty;
        force_word_t     w;
        fx = sum_x;
        fy = sum_y;
        sq = longint'(fx * fx) + longint'(fy * fy);
        if (active > 0 && sq > lrf_pkg::SQ_THRESH) begin
            den = longint'(root64(sq));
            if (den < lrf_pkg::UNIT_Q12) den = lrf_pkg::UNIT_Q12;
            fx = round_div(fx * weight, den);
            fy = round_div(fy * weight, den);
        end
        if (near_mm < lrf_pkg::NEAR_LIMIT) begin
            sin_cos(near_ang, s, c);
            if (near_ang < 0) begin
                tx = -s; ty = c;
            end else begin
                tx = s; ty = -c;
            end
            fx += round_div(longint'(tx) * lrf_pkg::TANGENT_Q12, lrf_pkg::Q14_ONE);
            fy += round_div(longint'(ty) * lrf_pkg::TANGENT_Q12, lrf_pkg::Q14_ONE);
        end
        w.fx = clip17(fx);
        w.fy = clip17(fy);
        w.fmin = front_mm[13:0];
        force_q.insert(force_q.size(), w);
        clear_scan();
    endtask

    always @(posedge aclk) begin
        force_word_t w;
        if (!aresetn) begin
            start_ang = -25736; end_ang = 25736; step = 143;
            cone = 11437; weight = 3686;
            clear_scan();
        end else begin
            if (m_tvalid && m_tready) begin
                if (force_q.size() == 0) begin
                    report($sformatf("unexpected force word %h", m_tdata));
                end else begin
                    w = force_q.pop_front();
                    if (m_tdata[16:0] !== w.fx)
                        report($sformatf("force_x %0d, want %0d",
                            $signed(m_tdata[16:0]), w.fx));
                    if (m_tdata[33:17] !== w.fy)
                        report($sformatf("force_y %0d, want %0d",
                            $signed(m_tdata[33:17]), w.fy));
                    if (m_tdata[47:34] !== w.fmin)
                        report($sformatf("front_min %0d, want %0d",
                            m_tdata[47:34], w.fmin));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lrf_pkg::CFG_START_ANGLE: start_ang = int'($signed(cfg_data));
                    lrf_pkg::CFG_END_ANGLE:   end_ang = int'($signed(cfg_data));
                    lrf_pkg::CFG_ANGLE_STEP:  step = int'(cfg_data[12:0]);
                    lrf_pkg::CFG_CONE_WIDTH:  cone = int'(cfg_data);
                    lrf_pkg::CFG_REP_WEIGHT:  weight = int'(cfg_data[13:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (!overrun) take_ray(s_tdata, s_tuser);
                if (s_tlast) finish_scan();
            end
        end
        pending = force_q.size();
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench for lidar_repulsion_field: drives lidar scans and register
// writes in phases of differing sender and receiver idling; lrf_checker
// predicts and compares each force word.
// ============================================================================
module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    int          errors, pending;
    int          idle_pct = 0;
    int          stall_pct = 0;

    always #10 aclk = ~aclk;

    lidar_repulsion_field u_top (.*);

    lrf_checker u_chk (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic put_ray(input logic [15:0] d, input bit no_echo, input bit last);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= no_echo;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every force word is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input int sa, input int ea, input int st, input int cw,
                             input int w);
        write_reg(lrf_pkg::CFG_START_ANGLE, 16'(sa));
        write_reg(lrf_pkg::CFG_END_ANGLE, 16'(ea));
        write_reg(lrf_pkg::CFG_ANGLE_STEP, 16'(st));
        write_reg(lrf_pkg::CFG_CONE_WIDTH, 16'(cw));
        write_reg(lrf_pkg::CFG_REP_WEIGHT, 16'(w));
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(0, 60));
            6:       return 16'($urandom_range(300, 400));
            7:       return 16'($urandom);
            8:       return 16'($urandom_range(9000, 10500));
            9:       return 16'($urandom_range(650, 750));
            default: return 16'($urandom_range(40, 800));
        endcase
    endfunction

    task automatic scan(input int n);
        for (int i = 0; i < n; i++)
            put_ray(pick_range(), $urandom_range(7) == 0, i == n - 1);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_items);
        int sent;
        sent = 0;
        idle_pct = idle;
        stall_pct = stall;
        while (sent < n_items) begin
            int n;
            n = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 24);
            scan(n);
            sent += n;
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_ray(16'd0, 0, 0);
        put_ray(16'd49, 0, 0);
        put_ray(16'd50, 0, 0);
        put_ray(16'd51, 0, 0);
        put_ray(16'd349, 0, 0);
        put_ray(16'd350, 0, 0);
        put_ray(16'd699, 0, 0);
        put_ray(16'd700, 0, 0);
        put_ray(16'hFFFF, 0, 0);
        put_ray(16'd300, 1, 1);
        put_ray(16'hFFFF, 1, 1);
        put_ray(16'd100, 0, 0);
        put_ray(16'd60000, 0, 1);
        put_ray(16'd200, 0, 1);
        run_phase(0, 0, 150);

        write_all(-25736, 25736, 4096, 51472, 8192);
        run_phase(83, 0, 150);

        write_all(25736, -25736, 1, 0, 0);
        run_phase(0, 83, 150);

        write_all($urandom_range(0, 51472) - 25736, $urandom_range(0, 51472) - 25736,
                  $urandom_range(40, 600), $urandom_range(0, 51472), $urandom_range(0, 8192));
        run_phase(36, 36, 150);

        write_all(-25736, 25736, 143, 11437, 3686);
        run_phase(0, 0, 120);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
